FILE: design/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared definitions for the compacting list table
// Sizes, request and status codes, the request and result records, and
// helpers that narrow internal counts to the result field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    // list size and derived widths
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WIDE_W   = (CNT_W > 9) ? CNT_W : 9;

    // field widths fixed by the interface
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] old_entry;
        logic signed [VAL_W-1:0] new_entry;
        logic [COUNT_W-1:0]      entry_count;
    } res_t;

    // low bits of a widened position
    function automatic logic [POS_W-1:0] low_pos(input logic [WIDE_W-1:0] v);
        return v[POS_W-1:0];
    endfunction

    // low bits of a widened count
    function automatic logic [COUNT_W-1:0] low_cnt(input logic [WIDE_W-1:0] v);
        return v[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/clt_ram.sv
// ----------------------------------------------------------------------------
// clt_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/clt_ctrl.sv
// ----------------------------------------------------------------------------
// clt_ctrl: request sequencer for the compacting list table
// Decodes one request at a time and walks the entry memory with a single
// pointer and comparator: a pipelined scan for find, a read-then-write for
// modify and a read-ahead copy loop that closes the gap for remove.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire clt_pkg::req_t in_req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output clt_pkg::res_t      res
);

    localparam int AW = clt_pkg::ADDR_W;
    localparam int CW = clt_pkg::CNT_W;
    localparam int WW = clt_pkg::WIDE_W;
    localparam int VW = clt_pkg::VAL_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_FIND = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_REM  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    clt_pkg::req_t       req_reg, req_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                vld_reg, vld_next;
    logic [AW-1:0]       aux_reg, aux_next;
    clt_pkg::res_t       res_reg, res_next;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [VW-1:0]       wdata;
    logic [AW-1:0]       raddr;
    logic [VW-1:0]       rdata;

    logic                idx_ok;
    logic                not_full;
    logic                ptr_live;
    logic                key_hit;
    logic [CW-1:0]       count_inc;
    logic [CW-1:0]       count_dec;
    logic [AW-1:0]       idx_addr;

    // entry store
    clt_ram #(
        .WIDTH (VW),
        .DEPTH (clt_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // shared compare and pointer arithmetic
    assign idx_ok    = WW'(req_reg.index) < WW'(count_reg);
    assign not_full  = WW'(count_reg) < WW'(clt_pkg::CAPACITY);
    assign ptr_live  = ptr_reg < count_reg;
    assign key_hit   = vld_reg && (rdata == req_reg.value);
    assign count_inc = CW'(count_reg + 1'b1);
    assign count_dec = CW'(count_reg - 1'b1);
    assign idx_addr  = AW'(req_reg.index);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // next-state and memory control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        ptr_next   = ptr_reg;
        vld_next   = vld_reg;
        aux_next   = aux_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_req;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (req_reg.req_type)
                    clt_pkg::REQ_FIND:
                    begin
                        ptr_next   = '0;
                        vld_next   = 1'b0;
                        state_next = ST_FIND;
                    end
                    clt_pkg::REQ_MODIFY:
                    begin
                        if (idx_ok)
                        begin
                            raddr      = idx_addr;
                            state_next = ST_MOD;
                        end
                        else
                        begin
                            res_next = '{clt_pkg::STAT_RANGE, req_reg.index, '0, '0,
                                         clt_pkg::low_cnt(WW'(count_reg))};
                            state_next = ST_DONE;
                        end
                    end
                    clt_pkg::REQ_APPEND:
                    begin
                        if (not_full)
                        begin
                            we         = 1'b1;
                            waddr      = AW'(count_reg);
                            wdata      = req_reg.value;
                            count_next = count_inc;
                            res_next   = '{clt_pkg::STAT_OK,
                                           clt_pkg::low_pos(WW'(count_reg)), '0,
                                           req_reg.value,
                                           clt_pkg::low_cnt(WW'(count_inc))};
                        end
                        else
                        begin
                            res_next = '{clt_pkg::STAT_FULL,
                                         clt_pkg::low_pos(WW'(count_reg)), '0, '0,
                                         clt_pkg::low_cnt(WW'(count_reg))};
                        end
                        state_next = ST_DONE;
                    end
                    clt_pkg::REQ_REMOVE:
                    begin
                        if (idx_ok)
                        begin
                            ptr_next   = CW'(CW'(req_reg.index) + 1'b1);
                            vld_next   = 1'b0;
                            state_next = ST_REM;
                        end
                        else
                        begin
                            res_next = '{clt_pkg::STAT_RANGE, req_reg.index, '0, '0,
                                         clt_pkg::low_cnt(WW'(count_reg))};
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end

            // read one entry a cycle, compare the one read the cycle before
            ST_FIND:
            begin
                priority if (key_hit)
                begin
                    res_next = '{clt_pkg::STAT_OK, clt_pkg::low_pos(WW'(aux_reg)),
                                 '0, '0, clt_pkg::low_cnt(WW'(count_reg))};
                    vld_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (ptr_live)
                begin
                    raddr    = AW'(ptr_reg);
                    aux_next = AW'(ptr_reg);
                    vld_next = 1'b1;
                    ptr_next = CW'(ptr_reg + 1'b1);
                end
                else
                begin
                    res_next = '{clt_pkg::STAT_NOT_FOUND, '0, '0, '0,
                                 clt_pkg::low_cnt(WW'(count_reg))};
                    vld_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end

            // old value is on the read port, overwrite in place
            ST_MOD:
            begin
                we       = 1'b1;
                waddr    = idx_addr;
                wdata    = req_reg.value;
                res_next = '{clt_pkg::STAT_OK, req_reg.index, rdata, req_reg.value,
                             clt_pkg::low_cnt(WW'(count_reg))};
                state_next = ST_DONE;
            end

            // read entry p, write it to p-1 on the next cycle
            ST_REM:
            begin
                if (vld_reg)
                begin
                    we    = 1'b1;
                    waddr = aux_reg;
                    wdata = rdata;
                end
                if (ptr_live)
                begin
                    raddr    = AW'(ptr_reg);
                    aux_next = AW'(ptr_reg - 1'b1);
                    vld_next = 1'b1;
                    ptr_next = CW'(ptr_reg + 1'b1);
                end
                else
                begin
                    vld_next = 1'b0;
                    if (!vld_reg)
                    begin
                        count_next = count_dec;
                        res_next   = '{clt_pkg::STAT_OK, req_reg.index, '0, '0,
                                       clt_pkg::low_cnt(WW'(count_dec))};
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            vld_reg   <= vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        ptr_reg <= ptr_next;
        aux_reg <= aux_next;
        res_reg <= res_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(count_reg) <= WW'(clt_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not decoded");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == CW'($past(count_reg) + 1'b1)) ||
             (count_reg == CW'($past(count_reg) - 1'b1))))
        else $error("entry count moved by more than one");

    a_no_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE || state_reg == ST_IDLE) |-> !we)
        else $error("memory written outside a request");

    a_handoff_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after handoff");

endmodule

`default_nettype wire

FILE: design/compacting_list_table.sv
// Each request is taken in idle, decoded in exec and held in done until the
// output register takes it; modify writes in a state of its own, and find and
// remove walk the list one entry per cycle through the single memory read port.
// A new request is taken the cycle after the previous result has left the
// sequencer.
// Reset clears the entry count and the handshakes; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// compacting_list_table: packed list of signed 32-bit entries
// Find, modify, append and remove on a fixed-capacity list, one request at a
// time, with a registered output stage for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_list_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // index[7:0], value[39:8]
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,  // position[7:0], old_entry[39:8],
                                       // new_entry[71:40], entry_count[80:72]
    output logic [1:0]       m_tuser   // status[1:0]
);

    clt_pkg::req_t in_req;
    clt_pkg::res_t res;
    logic          res_valid;
    logic          res_ready;
    logic          out_valid_reg;
    clt_pkg::res_t out_res_reg;

    // unpack the request
    assign in_req.req_type = s_tuser;
    assign in_req.index    = s_tdata[7:0];
    assign in_req.value    = s_tdata[39:8];

    clt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    // pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {7'd0, out_res_reg.entry_count, out_res_reg.new_entry,
                       out_res_reg.old_entry, out_res_reg.position};

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for compacting_list_table
// Drives find, modify, append and remove requests over the slave stream and
// checks every result on the master stream against a behavioural list kept
// in the bench. A short scripted opening covers the empty list, the value
// extremes and the ok, not-found and range status codes; random phases then
// grow, shrink and fill the list, with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import clt_pkg::*;

    typedef enum int {PH_MIXED, PH_GROW, PH_SHRINK, PH_FILL} phase_t;

    typedef struct {
        logic [REQ_W-1:0] op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        bit               typed;
        res_t             want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // index[7:0], value[39:8]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;        // position[7:0], old_entry[39:8],
                                 // new_entry[71:40], entry_count[80:72]
    logic [1:0]  m_tuser;        // status[1:0]

    // shadow copy of the list
    logic [VAL_W-1:0] list_mem [CAPACITY];
    int               list_count = 0;

    res_t        results_due [$];
    script_row_t script [$];
    int          fail_count = 0;
    int          sent_total = 0;
    int          op_seen [4] = '{0, 0, 0, 0};
    int          status_seen [4] = '{0, 0, 0, 0};
    int          deepest = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    res_t        mon_got;
    res_t        mon_want;

    compacting_list_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // list behaviour: applies one request and returns its result
    function automatic res_t list_apply(input logic [REQ_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [VAL_W-1:0] val);
        res_t r;
        int   i;
        r = '0;
        case (op)
            REQ_FIND:
            begin
                r.status = STAT_NOT_FOUND;
                // walk downwards so the lowest match is kept
                for (i = list_count - 1; i >= 0; i--)
                begin
                    if (list_mem[i] == val)
                    begin
                        r.status   = STAT_OK;
                        r.position = i[POS_W-1:0];
                    end
                end
            end
            REQ_MODIFY:
            begin
                r.position = idx;
                if (idx < list_count)
                begin
                    r.status      = STAT_OK;
                    r.old_entry   = list_mem[idx];
                    r.new_entry   = val;
                    list_mem[idx] = val;
                end
                else
                begin
                    r.status = STAT_RANGE;
                end
            end
            REQ_APPEND:
            begin
                r.position = list_count[POS_W-1:0];
                if (list_count < CAPACITY)
                begin
                    r.status             = STAT_OK;
                    r.new_entry          = val;
                    list_mem[list_count] = val;
                    list_count++;
                end
                else
                begin
                    r.status = STAT_FULL;
                end
            end
            default:
            begin
                r.position = idx;
                if (idx < list_count)
                begin
                    r.status = STAT_OK;
                    for (i = idx; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_count--;
                end
                else
                begin
                    r.status = STAT_RANGE;
                end
            end
        endcase
        r.entry_count = list_count[COUNT_W-1:0];
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit enabled);
        int p;
        p = $urandom_range(99, 0);
        if (!enabled || p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(3, 1);
        return $urandom_range(50, 10);
    endfunction

    // values: live entries, a small pool with many repeats, or anything
    function automatic logic [VAL_W-1:0] pick_value();
        int p;
        p = $urandom_range(9, 0);
        if (p < 4 && list_count > 0)
            return list_mem[$urandom_range(list_count - 1, 0)];
        if (p < 7)
            return $urandom_range(7, 0) - 4;
        return $urandom();
    endfunction

    // index: mostly a live position, otherwise anywhere in the field
    function automatic logic [IDX_W-1:0] pick_index();
        int p;
        p = $urandom_range(9, 0);
        if (p < 8 && list_count > 0)
            return IDX_W'($urandom_range(list_count - 1, 0));
        return IDX_W'($urandom_range(255, 0));
    endfunction

    function automatic void add_row(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
                                    input logic [VAL_W-1:0] val, input bit typed,
                                    input logic [STAT_W-1:0] st, input logic [POS_W-1:0] pos,
                                    input logic [VAL_W-1:0] old_v,
                                    input logic [VAL_W-1:0] new_v,
                                    input logic [COUNT_W-1:0] cnt);
        script_row_t row;
        row.op    = op;
        row.idx   = idx;
        row.val   = val;
        row.typed = typed;
        row.want  = '{st, pos, old_v, new_v, cnt};
        script.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // one request: optional gap, then hold until taken
    task automatic send_req(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val, input bit typed, input res_t want);
        res_t pred;
        int   gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, idx};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = list_apply(op, idx, val);
        results_due.push_back(typed ? want : pred);
        sent_total++;
        op_seen[op]++;
        status_seen[pred.status]++;
        if (list_count > deepest)
            deepest = list_count;
    endtask

    // stop sending until every result is back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic run_phase(input phase_t kind, input int len);
        int               n;
        int               p;
        logic [REQ_W-1:0] op;
        for (n = 0; n < len; n++)
        begin
            p = $urandom_range(99, 0);
            case (kind)
                PH_GROW:
                    op = (p < 55) ? REQ_APPEND : (p < 75) ? REQ_FIND :
                         (p < 90) ? REQ_MODIFY : REQ_REMOVE;
                PH_SHRINK:
                    op = (p < 50) ? REQ_REMOVE : (p < 70) ? REQ_FIND :
                         (p < 85) ? REQ_MODIFY : REQ_APPEND;
                PH_FILL:
                    if (list_count < CAPACITY)
                        op = (p < 85) ? REQ_APPEND : (p < 95) ? REQ_FIND : REQ_MODIFY;
                    else
                        op = (p < 40) ? REQ_APPEND : (p < 60) ? REQ_FIND :
                             (p < 80) ? REQ_MODIFY : REQ_REMOVE;
                default:
                    op = p[1:0];
            endcase
            send_req(op, pick_index(), pick_value(), 1'b0, '0);
        end
    endtask

    // result ready with random stalls
    initial
    begin : sink_ready
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            hold = $urandom_range(12, 1);
            repeat (hold) @(posedge clk);
            hold = pick_gap(rx_idle_on);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mon_got.status      = m_tuser;
            mon_got.position    = m_tdata[7:0];
            mon_got.old_entry   = m_tdata[39:8];
            mon_got.new_entry   = m_tdata[71:40];
            mon_got.entry_count = m_tdata[80:72];
            if (results_due.size() == 0)
            begin
                $error("result with nothing expected: status %0d position %0d",
                       mon_got.status, mon_got.position);
                fail_count++;
            end
            else
            begin
                mon_want = results_due.pop_front();
                check_field("status", 32'(mon_want.status), 32'(mon_got.status));
                check_field("position", 32'(mon_want.position), 32'(mon_got.position));
                check_field("old_entry", mon_want.old_entry, mon_got.old_entry);
                check_field("new_entry", mon_want.new_entry, mon_got.new_entry);
                check_field("entry_count", 32'(mon_want.entry_count),
                            32'(mon_got.entry_count));
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        int     phase_no;
        phase_t kind;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, extremes, duplicates, first and last positions
        add_row(REQ_FIND,   8'd0,   32'h0000_0000, 1'b1, STAT_NOT_FOUND, 8'd0, 0, 0, 9'd0);
        add_row(REQ_REMOVE, 8'd0,   32'h0000_0000, 1'b1, STAT_RANGE, 8'd0, 0, 0, 9'd0);
        add_row(REQ_MODIFY, 8'd255, 32'h0000_0001, 1'b1, STAT_RANGE, 8'd255, 0, 0, 9'd0);
        add_row(REQ_APPEND, 8'd0,   32'h7FFF_FFFF, 1'b1, STAT_OK, 8'd0, 0, 32'h7FFF_FFFF, 9'd1);
        add_row(REQ_APPEND, 8'd255, 32'h8000_0000, 1'b1, STAT_OK, 8'd1, 0, 32'h8000_0000, 9'd2);
        add_row(REQ_APPEND, 8'd0,   32'h0000_0000, 1'b1, STAT_OK, 8'd2, 0, 0, 9'd3);
        add_row(REQ_APPEND, 8'd0,   32'hFFFF_FFFF, 1'b1, STAT_OK, 8'd3, 0, 32'hFFFF_FFFF, 9'd4);
        add_row(REQ_APPEND, 8'd0,   32'h8000_0000, 1'b1, STAT_OK, 8'd4, 0, 32'h8000_0000, 9'd5);
        add_row(REQ_FIND,   8'd0,   32'h8000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_FIND,   8'd255, 32'hFFFF_FFFF, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_FIND,   8'd0,   32'h1234_5678, 1'b1, STAT_NOT_FOUND, 8'd0, 0, 0, 9'd5);
        add_row(REQ_FIND,   8'd0,   32'h7FFF_FFFF, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_MODIFY, 8'd0,   32'hAAAA_AAAA, 1'b1, STAT_OK, 8'd0, 32'h7FFF_FFFF,
                32'hAAAA_AAAA, 9'd5);
        add_row(REQ_MODIFY, 8'd4,   32'h5555_5555, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_MODIFY, 8'd5,   32'h0000_0001, 1'b1, STAT_RANGE, 8'd5, 0, 0, 9'd5);
        add_row(REQ_REMOVE, 8'd1,   32'h0000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_FIND,   8'd0,   32'h8000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_REMOVE, 8'd3,   32'h0000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_REMOVE, 8'd3,   32'h0000_0000, 1'b1, STAT_RANGE, 8'd3, 0, 0, 9'd3);
        add_row(REQ_REMOVE, 8'd0,   32'h0000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_FIND,   8'd0,   32'h0000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_REMOVE, 8'd1,   32'h0000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_REMOVE, 8'd0,   32'h0000_0000, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);
        add_row(REQ_FIND,   8'd0,   32'h0000_0000, 1'b1, STAT_NOT_FOUND, 8'd0, 0, 0, 9'd0);
        add_row(REQ_APPEND, 8'd0,   32'h0000_0001, 1'b0, STAT_OK, 8'd0, 0, 0, 9'd0);

        foreach (script[k])
            send_req(script[k].op, script[k].idx, script[k].val, script[k].typed,
                     script[k].want);
        hold_until_drained();

        // random phases; the second and sixth run the list up to full
        phase_no = 0;
        while (sent_total < 2000)
        begin
            if (phase_no == 1 || phase_no == 5)
                kind = PH_FILL;
            else
                kind = phase_t'($urandom_range(2, 0));
            tx_idle_on = ($urandom_range(3, 0) != 0);
            rx_idle_on = ($urandom_range(3, 0) != 0);
            run_phase(kind, (kind == PH_FILL) ? 400 : $urandom_range(180, 60));
            if (phase_no == 0 || $urandom_range(1, 0) == 0)
                hold_until_drained();
            phase_no++;
        end

        // wait for the tail, then watch for stray results
        hold_until_drained();
        repeat (300) @(posedge clk);

        $display("%0d requests: %0d find, %0d modify, %0d append, %0d remove; deepest list %0d",
                 sent_total, op_seen[REQ_FIND], op_seen[REQ_MODIFY], op_seen[REQ_APPEND],
                 op_seen[REQ_REMOVE], deepest);
        $display("status mix: %0d ok, %0d not found, %0d out of range, %0d full",
                 status_seen[STAT_OK], status_seen[STAT_NOT_FOUND],
                 status_seen[STAT_RANGE], status_seen[STAT_FULL]);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
